// File: hw/rtl/acss_pkg.sv
// ----------------------------------------------------------------------------
// acss_pkg - shared types and constants for the ADC channel scan sequencer
// Request and response layouts, scan phase encoding and the channel remap.
// ----------------------------------------------------------------------------
package acss_pkg;

    localparam int MAX_CHANNELS_DEF = 8;   // default scan store depth
    localparam int MAX_CHANNELS_LIM = 16;  // largest supported depth
    localparam int IDX_MAX_W        = 4;   // index width at the largest depth
    localparam int CNT_W            = 5;   // holds a channel count up to the limit
    localparam int CFG_W            = 4;
    localparam int RES_W            = 10;
    localparam int VAL_W            = 8;
    localparam int CH_IN_W          = 3;
    localparam int MUX_W            = 3;
    localparam int IN_TDATA_W       = 16;
    localparam int OUT_TDATA_W      = 16;

    localparam logic [CFG_W-1:0] NUM_CH_RST   = 4'd1;

    // three-channel boards wire logical channel 2 to mux input 3
    localparam logic [CNT_W-1:0] REMAP_COUNT  = 5'd3;
    localparam logic [CNT_W-1:0] REMAP_LCHAN  = 5'd2;
    localparam logic [MUX_W-1:0] REMAP_MUX    = 3'd3;

    typedef enum logic [1:0] {
        PH_SELECT = 2'd0,
        PH_WAIT   = 2'd1,
        PH_START  = 2'd2,
        PH_CONV   = 2'd3
    } t_phase;

    typedef enum logic {
        FUNC_POLL = 1'b0,
        FUNC_READ = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic               conv_busy;
        logic [RES_W-1:0]   conv_result;
        logic [CH_IN_W-1:0] read_chan;
    } t_req;

    typedef struct packed {
        logic               select_valid;
        logic [MUX_W-1:0]   select_mux;
        logic               conv_start;
        logic               sample_stored;
        logic [VAL_W-1:0]   read_value;
    } t_rsp;

    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
        logic [VAL_W-1:0]     data;
    } t_store_wr;

endpackage

// File: hw/rtl/acss_store.sv
// ----------------------------------------------------------------------------
// acss_store - per-channel sample store
// One write port from the sequencer, one read port for read requests.
// ----------------------------------------------------------------------------
module acss_store #(
    parameter int MAX_CHANNELS = acss_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  acss_pkg::t_store_wr            i_wr,
    input  logic [acss_pkg::CH_IN_W-1:0]   i_rd_chan,
    output logic [acss_pkg::VAL_W-1:0]     o_rd_data
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [acss_pkg::VAL_W-1:0] r_val [MAX_CHANNELS];
    logic [acss_pkg::CNT_W-1:0] w_rd_ext;
    logic [IDX_W-1:0]           w_rd_idx;
    logic [IDX_W-1:0]           w_wr_idx;

    assign w_rd_ext = acss_pkg::CNT_W'(i_rd_chan);
    assign w_rd_idx = w_rd_ext[IDX_W-1:0];
    assign w_wr_idx = i_wr.idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_val[k] <= '0;
            end
        end else if (i_wr.en) begin
            r_val[w_wr_idx] <= i_wr.data;
        end
    end

    // channels past the store depth read as zero
    always_comb begin
        if (w_rd_ext < acss_pkg::CNT_W'(MAX_CHANNELS)) begin
            o_rd_data = r_val[w_rd_idx];
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

// File: hw/rtl/acss_seq.sv
// ----------------------------------------------------------------------------
// acss_seq - scan phase sequencer
// Holds the channel count, scan phase and current channel; forms one response.
// ----------------------------------------------------------------------------
module acss_seq #(
    parameter int MAX_CHANNELS = acss_pkg::MAX_CHANNELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [acss_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_step,
    input  acss_pkg::t_req               i_req,
    input  logic [acss_pkg::VAL_W-1:0]   i_rd_data,
    output acss_pkg::t_rsp               o_rsp,
    output acss_pkg::t_store_wr          o_wr,
    output acss_pkg::t_phase             o_phase
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [acss_pkg::CNT_W-1:0] MAX_CNT = acss_pkg::CNT_W'(MAX_CHANNELS);

    logic [acss_pkg::CFG_W-1:0] r_num_ch;
    acss_pkg::t_phase           r_phase, n_phase;
    logic [IDX_W-1:0]           r_chan, n_chan;

    logic [acss_pkg::CNT_W-1:0] w_num_ext;
    logic [acss_pkg::CNT_W-1:0] w_count;
    logic [acss_pkg::CNT_W-1:0] w_chan_ext;
    logic [acss_pkg::CNT_W-1:0] w_chan_inc;
    logic [acss_pkg::CNT_W-1:0] w_mux_ch;
    logic                       w_poll;

    assign w_num_ext  = acss_pkg::CNT_W'(r_num_ch);
    assign w_chan_ext = acss_pkg::CNT_W'(r_chan);
    assign w_chan_inc = w_chan_ext + 1'b1;
    assign w_poll     = (i_req.func == acss_pkg::FUNC_POLL);

    // clamp the programmed count to 1..MAX_CHANNELS
    always_comb begin
        if (w_num_ext == '0) begin
            w_count = acss_pkg::CNT_W'(1);
        end else if (w_num_ext > MAX_CNT) begin
            w_count = MAX_CNT;
        end else begin
            w_count = w_num_ext;
        end
    end

    always_comb begin
        if (w_count == acss_pkg::REMAP_COUNT && w_chan_ext == acss_pkg::REMAP_LCHAN) begin
            w_mux_ch = acss_pkg::CNT_W'(acss_pkg::REMAP_MUX);
        end else begin
            w_mux_ch = w_chan_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch <= acss_pkg::NUM_CH_RST;
            r_phase  <= acss_pkg::PH_SELECT;
            r_chan   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num_ch <= i_cfg_wdata;
            end
            if (i_step) begin
                r_phase <= n_phase;
                r_chan  <= n_chan;
            end
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_chan  = r_chan;
        if (w_poll) begin
            unique case (r_phase)
                acss_pkg::PH_SELECT: n_phase = acss_pkg::PH_WAIT;
                acss_pkg::PH_WAIT:   n_phase = acss_pkg::PH_START;
                acss_pkg::PH_START:  n_phase = acss_pkg::PH_CONV;
                acss_pkg::PH_CONV: begin
                    if (!i_req.conv_busy) begin
                        n_phase = acss_pkg::PH_SELECT;
                        // wrap, also when the count was lowered mid-scan
                        if (w_chan_inc >= w_count) begin
                            n_chan = '0;
                        end else begin
                            n_chan = w_chan_inc[IDX_W-1:0];
                        end
                    end
                end
                default: n_phase = acss_pkg::PH_SELECT;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_rsp     = '0;
        o_wr.en   = 1'b0;
        o_wr.idx  = acss_pkg::IDX_MAX_W'(r_chan);
        o_wr.data = i_req.conv_result[acss_pkg::RES_W-1 -: acss_pkg::VAL_W];
        if (!w_poll) begin
            o_rsp.read_value = i_rd_data;
        end else begin
            unique case (r_phase)
                acss_pkg::PH_SELECT: begin
                    o_rsp.select_valid = 1'b1;
                    o_rsp.select_mux   = w_mux_ch[acss_pkg::MUX_W-1:0];
                end
                acss_pkg::PH_WAIT: begin
                    o_rsp = '0;
                end
                acss_pkg::PH_START: begin
                    o_rsp.conv_start = 1'b1;
                end
                acss_pkg::PH_CONV: begin
                    if (!i_req.conv_busy) begin
                        o_rsp.sample_stored = 1'b1;
                        o_wr.en = i_step && (w_chan_ext < MAX_CNT);
                    end
                end
                default: o_rsp = '0;
            endcase
        end
    end

    assign o_phase = r_phase;

endmodule

// File: hw/rtl/adc_channel_scan_sequencer_top.sv
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer_top - round-robin ADC channel scan controller
// Steps a select/wait/start/convert sequence on poll requests and serves reads.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata, tuser (func)
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata
//  cfg       in         i_cfg_we                       i_cfg_wdata (num_channels)
//
//  One request per cycle sustained while the output is not stalled; each response
//  passes through the input register, then the result register.
//  Phase, channel and store update in the cycle a request moves into the result
//  register, so a read right after a store sees the new value.
//  Synchronous active-low reset clears phase, channel, store and sets count 1.
//  A stalled output holds; s_axis_tready drops only when both registers are full.
//
module adc_channel_scan_sequencer_top #(
    parameter int MAX_CHANNELS = acss_pkg::MAX_CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [acss_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // conv_busy[0], conv_result[10:1], read_chan[13:11], zero[15:14]
    input  logic [acss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // select_valid[0], select_mux[3:1], conv_start[4], sample_stored[5],
    // read_value[13:6], zero[15:14]
    output logic [acss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic                r_in_valid;
    acss_pkg::t_req      r_in;
    logic                r_out_valid;
    acss_pkg::t_rsp      r_out;

    logic                w_out_free;
    logic                w_step;
    acss_pkg::t_req      w_req;
    acss_pkg::t_rsp      w_rsp;
    acss_pkg::t_store_wr w_wr;
    acss_pkg::t_phase    w_phase;
    logic [acss_pkg::VAL_W-1:0] w_rd_data;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    assign w_req.func        = acss_pkg::t_func'(s_axis_tuser);
    assign w_req.conv_busy   = s_axis_tdata[0];
    assign w_req.conv_result = s_axis_tdata[acss_pkg::RES_W:1];
    assign w_req.read_chan   = s_axis_tdata[acss_pkg::RES_W+acss_pkg::CH_IN_W:acss_pkg::RES_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= w_req;
        end
        if (w_step) begin
            r_out <= w_rsp;
        end
    end

    acss_seq #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_req       (r_in),
        .i_rd_data   (w_rd_data),
        .o_rsp       (w_rsp),
        .o_wr        (w_wr),
        .o_phase     (w_phase)
    );

    acss_store #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_chan (r_in.read_chan),
        .o_rd_data (w_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.read_value, r_out.sample_stored, r_out.conv_start,
                            r_out.select_mux, r_out.select_valid};

    // input stage stalls only behind a held response
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a held response");

    // at most one sequencing action per response
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones({r_out.select_valid, r_out.conv_start,
                                       r_out.sample_stored}) <= 1))
        else $error("response carries more than one sequencing action");

    // a store write happens only on a stepped poll in the convert phase
    a_store_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (w_step && w_phase == acss_pkg::PH_CONV &&
                     r_in.func == acss_pkg::FUNC_POLL && !r_in.conv_busy))
        else $error("store written outside the convert phase");

    // a stepped select poll always moves on to the wait phase
    a_select_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.func == acss_pkg::FUNC_POLL && w_phase == acss_pkg::PH_SELECT)
        |=> (w_phase == acss_pkg::PH_WAIT))
        else $error("select phase did not advance");

endmodule
